### rtl/core/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BBL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define BBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/core/bbl_pkg.sv
// Types and constants of the box blur line filter
package bbl_pkg;

	localparam int PIX_W  = 32;
	localparam int CH_W   = 8;
	localparam int NCH    = 4;
	localparam int RAD_W  = 6;
	localparam int QUO_W  = 8;
	localparam int QDEPTH = 2;

	localparam logic [RAD_W-1:0] RADIUS_RESET = 6'd2;

	// one classified input pixel as handed from front to back
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             line_end;
		logic             pass;
		logic [RAD_W-1:0] radius;
		logic [RAD_W-1:0] pushes;
	} item_t;

endpackage

### rtl/core/bbl_if.sv
// Stream interfaces for pixels in and results out

interface bbl_pix_if;
	logic                       valid;
	logic                       ready;
	logic [bbl_pkg::PIX_W-1:0]  pixel_in;
	logic                       line_end;

	modport source(output valid, output pixel_in, output line_end, input ready);
	modport sink(input valid, input pixel_in, input line_end, output ready);
endinterface

interface bbl_res_if;
	logic                       valid;
	logic                       ready;
	logic [bbl_pkg::PIX_W-1:0]  pixel_out;
	logic                       run_last;
	logic                       line_done;

	modport source(output valid, output pixel_out, output run_last, output line_done,
		input ready);
	modport sink(input valid, input pixel_out, input run_last, input line_done,
		output ready);
endinterface

### rtl/core/bbl_front.sv
// Front end: radius register, input transfer and classification of each pixel
module bbl_front #(
	parameter int MAX_RADIUS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bbl_pkg::RAD_W-1:0]  cfg_data,
	bbl_pix_if.sink                    pixels,
	input  logic                       q_full,
	output logic                       q_push,
	output bbl_pkg::item_t             q_item
);

	// the radius register is 6 bits, so no window ever spans more than 63 pixels
	localparam int DEPTH = (MAX_RADIUS < 63) ? MAX_RADIUS : 63;

	logic [bbl_pkg::RAD_W-1:0] radius_q;
	logic [bbl_pkg::RAD_W-1:0] r_eff;
	logic [bbl_pkg::RAD_W-1:0] half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= bbl_pkg::RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_data;
		end
	end

	always_comb begin
		if ({1'b0, radius_q} > 7'(DEPTH)) begin
			r_eff = bbl_pkg::RAD_W'(DEPTH);
		end else begin
			r_eff = radius_q;
		end
		half = r_eff >> 1;
	end

	assign pixels.ready = !q_full;
	assign q_push       = pixels.valid && !q_full;

	always_comb begin
		q_item.pixel    = pixels.pixel_in;
		q_item.line_end = pixels.line_end;
		q_item.pass     = r_eff < bbl_pkg::RAD_W'(2);
		q_item.radius   = r_eff;
		// a line end flushes half a window of repeated pixels
		if (pixels.line_end && !q_item.pass) begin
			q_item.pushes = half + bbl_pkg::RAD_W'(1);
		end else begin
			q_item.pushes = bbl_pkg::RAD_W'(1);
		end
	end

endmodule

### rtl/core/bbl_queue.sv
// Short queue of classified items between front and back
module bbl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bbl_pkg::item_t  push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output bbl_pkg::item_t  head
);

	localparam int PW = $clog2(bbl_pkg::QDEPTH);

	bbl_pkg::item_t entries_q [bbl_pkg::QDEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [PW:0]    cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full       = cnt_q == (PW+1)'(bbl_pkg::QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = entries_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_q] <= push_item;
		end
	end

endmodule

### rtl/core/bbl_back.sv
// Back end: window shift line, two-stage window adder tree, divider, result register
module bbl_back #(
	parameter int MAX_RADIUS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  bbl_pkg::item_t  q_item,
	output logic            q_pop,
	bbl_res_if.source       results
);

	localparam int DEPTH = (MAX_RADIUS < 63) ? MAX_RADIUS : 63;
	localparam int FW    = $clog2(DEPTH + 1);
	localparam int SW    = bbl_pkg::CH_W + $clog2(DEPTH + 1);
	localparam int NG    = (DEPTH + 7) / 8;
	localparam int GW    = bbl_pkg::CH_W + 3;
	localparam int STW   = $clog2(bbl_pkg::QUO_W);
	localparam int CW    = bbl_pkg::CH_W;
	localparam int RW    = bbl_pkg::RAD_W;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PUSH = 6'b000010,
		ST_SUM1 = 6'b000100,
		ST_SUM2 = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t                    state_q;
	logic [bbl_pkg::PIX_W-1:0] store_q [DEPTH];
	logic [FW-1:0]             fed_q;
	logic [RW-1:0]             left_q;

	logic [GW-1:0]             part_s1 [bbl_pkg::NCH][NG];
	logic [SW-1:0]             rem_q   [bbl_pkg::NCH];
	logic [bbl_pkg::QUO_W-1:0] quo_q   [bbl_pkg::NCH];
	logic [SW-1:0]             dvs_q;
	logic [STW-1:0]            step_q;

	logic                      out_valid_q;
	logic [bbl_pkg::PIX_W-1:0] out_pix_q;
	logic                      out_last_q;
	logic                      out_done_q;

	logic                      emit;
	logic                      last_push;
	logic                      out_free;
	logic                      finish;
	logic [GW-1:0]             part_d [bbl_pkg::NCH][NG];
	logic [SW-1:0]             tot_d  [bbl_pkg::NCH];
	logic [bbl_pkg::PIX_W-1:0] mean_pix;

	assign emit      = 7'(fed_q) >= 7'(q_item.radius >> 1);
	assign last_push = left_q == RW'(1);
	assign out_free  = !out_valid_q || results.ready;
	assign finish    = (state_q == ST_PUSH && !q_item.pass && !emit && last_push) ||
		(state_q == ST_OUT && out_free && left_q == '0);
	assign q_pop     = finish;

	// first tree level: groups of eight taps, taps past the radius masked off
	always_comb begin
		int idx;
		for (int c = 0; c < bbl_pkg::NCH; c++) begin
			for (int g = 0; g < NG; g++) begin
				part_d[c][g] = '0;
				for (int k = 0; k < 8; k++) begin
					idx = g * 8 + k;
					if (idx < DEPTH) begin
						if (idx < int'(q_item.radius)) begin
							part_d[c][g] = part_d[c][g] + GW'(store_q[idx][c*CW +: CW]);
						end
					end
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < bbl_pkg::NCH; c++) begin
			tot_d[c] = '0;
			for (int g = 0; g < NG; g++) begin
				tot_d[c] = tot_d[c] + SW'(part_s1[c][g]);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < bbl_pkg::NCH; c++) begin
			mean_pix[c*CW +: CW] = quo_q[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fed_q       <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DEPTH; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						left_q  <= q_item.pushes;
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					for (int i = DEPTH - 1; i > 0; i--) begin
						store_q[i] <= store_q[i-1];
					end
					store_q[0] <= q_item.pixel;
					if (fed_q < FW'(DEPTH)) begin
						fed_q <= fed_q + FW'(1);
					end
					left_q <= left_q - RW'(1);
					if (q_item.pass) begin
						state_q <= ST_OUT;
					end else if (emit) begin
						state_q <= ST_SUM1;
					end else if (last_push) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SUM1: begin
					state_q <= ST_SUM2;
				end
				ST_SUM2: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (left_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_PUSH;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// a finished line leaves an empty window for the next one
			if (finish && q_item.line_end) begin
				fed_q <= '0;
				for (int i = 0; i < DEPTH; i++) begin
					store_q[i] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SUM1) begin
			part_s1 <= part_d;
		end
		if (state_q == ST_SUM2) begin
			for (int c = 0; c < bbl_pkg::NCH; c++) begin
				rem_q[c] <= tot_d[c];
				quo_q[c] <= '0;
			end
			dvs_q  <= SW'(q_item.radius) << (bbl_pkg::QUO_W - 1);
			step_q <= STW'(bbl_pkg::QUO_W - 1);
		end
		// restoring division, one quotient bit per cycle in all four channels
		if (state_q == ST_DIV) begin
			for (int c = 0; c < bbl_pkg::NCH; c++) begin
				if (rem_q[c] >= dvs_q) begin
					rem_q[c] <= rem_q[c] - dvs_q;
					quo_q[c] <= {quo_q[c][bbl_pkg::QUO_W-2:0], 1'b1};
				end else begin
					quo_q[c] <= {quo_q[c][bbl_pkg::QUO_W-2:0], 1'b0};
				end
			end
			dvs_q  <= dvs_q >> 1;
			step_q <= step_q - STW'(1);
		end
		if (state_q == ST_OUT && out_free) begin
			out_pix_q  <= q_item.pass ? q_item.pixel : mean_pix;
			out_last_q <= left_q == '0;
			out_done_q <= (left_q == '0) && q_item.line_end;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.pixel_out = out_pix_q;
	assign results.run_last  = out_last_q;
	assign results.line_done = out_done_q;

endmodule

### rtl/core/box_blur_line_filter_top.sv
// Top level of the box blur line filter
//
//  channel        dir  handshake      payload
//  pixel_stream   in   valid/ready    pixel_in[31:0], line_end
//  result_stream  out  valid/ready    pixel_out[31:0], run_last, line_done
//  cfg            in   cfg_we         cfg_data[5:0] (window radius)
//
// Each item starts in idle. A pass-through pixel goes through push and result load; each
// filtered window push goes through push, two adder tree stages, 8 divider steps, result load.
// A filtered line_end pixel makes 1 + radius/2 pushes. The shared 8-step divider sets the rate.
// Reset clears the radius to 2, the window and the queue; no clearing pass.
// The two-entry queue lets the front take pixels while the back waits on result_stream.
module box_blur_line_filter_top #(
	parameter int MAX_RADIUS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bbl_pkg::RAD_W-1:0]  cfg_data,
	bbl_pix_if.sink                    pixel_stream,
	bbl_res_if.source                  result_stream
);

	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_valid;
	bbl_pkg::item_t push_item;
	bbl_pkg::item_t head_item;

	bbl_front #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.pixels  (pixel_stream),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (push_item)
	);

	bbl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head      (head_item)
	);

	bbl_back #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_item (head_item),
		.q_pop  (q_pop),
		.results(result_stream)
	);

endmodule

### rtl/core/bbl_checker.sv
// Port-level checker of the box blur line filter and its bind
`include "assert_macros.svh"

module bbl_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [bbl_pkg::PIX_W-1:0]  out_pixel,
	input logic                       out_last,
	input logic                       out_done
);

	// set once any pixel has been transferred in
	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			seen_q <= 1'b1;
		end
	end

	`BBL_ASSERT_IMP(a_done_is_last, clk, arst_n, out_valid && out_done, out_last)
	`BBL_ASSERT_IMP(a_no_result_before_input, clk, arst_n, out_valid, seen_q)
	`BBL_ASSERT_NEXT(a_valid_held, clk, arst_n, out_valid && !out_ready, out_valid)
	`BBL_ASSERT_NEXT(a_result_held, clk, arst_n, out_valid && !out_ready, $stable(out_pixel) && $stable(out_last) && $stable(out_done))

endmodule

bind box_blur_line_filter_top bbl_checker u_bbl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (pixel_stream.valid),
	.in_ready (pixel_stream.ready),
	.out_valid(result_stream.valid),
	.out_ready(result_stream.ready),
	.out_pixel(result_stream.pixel_out),
	.out_last (result_stream.run_last),
	.out_done (result_stream.line_done)
);

### tb/box_blur_line_filter_top_tb.sv
// Self-checking testbench of the box blur line filter: stream driver, predictor and result checker
module box_blur_line_filter_top_tb;

	localparam int MAX_R      = 32;
	localparam int SETTLE_CYC = 300;     // covers a full line-end flush at the largest radius
	localparam int LIMIT      = 500000;
	localparam int PHASES     = 10;
	localparam int PHASE_PIX  = 11;

	typedef enum logic [1:0] {ST_PIXEL, ST_RADIUS, ST_DRAIN} stim_kind_t;

	typedef struct {
		stim_kind_t                kind;
		logic [bbl_pkg::PIX_W-1:0] pixel;
		logic                      line_end;
		logic [bbl_pkg::RAD_W-1:0] radius;
		bit                        calm;
	} stim_t;

	typedef struct packed {
		logic [bbl_pkg::PIX_W-1:0] pixel;
		logic                      run_last;
		logic                      line_done;
	} blur_out_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we = 1'b0;
	logic [bbl_pkg::RAD_W-1:0] cfg_data = '0;

	bbl_pix_if pix_if();
	bbl_res_if res_if();

	box_blur_line_filter_top #(.MAX_RADIUS(MAX_R)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.pixel_stream (pix_if),
		.result_stream(res_if)
	);

	always #5 clk = ~clk;

	stim_t       stim_q[$];
	blur_out_t   blur_expect_q[$];
	int          errors = 0;
	int          n_pixels = 0;
	int          n_lines = 0;
	int          n_radius_writes = 0;
	int          n_checked = 0;

	// predictor state
	logic [bbl_pkg::PIX_W-1:0] window_hist[MAX_R];
	int                        line_pushes;
	logic [bbl_pkg::RAD_W-1:0] radius_reg;

	function automatic void clear_window();
		foreach (window_hist[i])
			window_hist[i] = '0;
		line_pushes = 0;
	endfunction

	// shift one pixel into the window; returns 1 when this push owes a result
	function automatic bit window_push(input logic [bbl_pkg::PIX_W-1:0] px, input int r,
		output logic [bbl_pkg::PIX_W-1:0] mean);
		int pos;
		int sum;
		int q;
		pos = line_pushes;
		for (int i = MAX_R - 1; i > 0; i--)
			window_hist[i] = window_hist[i-1];
		window_hist[0] = px;
		if (line_pushes < MAX_R)
			line_pushes++;
		mean = '0;
		if (r < 2 || pos < r / 2)
			return 1'b0;
		for (int ch = 0; ch < bbl_pkg::NCH; ch++) begin
			sum = 0;
			for (int i = 0; i < r; i++)
				sum += window_hist[i][bbl_pkg::CH_W*ch +: bbl_pkg::CH_W];
			q = sum / r;
			if (q > 255)
				q = 255;
			mean[bbl_pkg::CH_W*ch +: bbl_pkg::CH_W] = q[bbl_pkg::CH_W-1:0];
		end
		return 1'b1;
	endfunction

	task automatic predict_blur(input logic [bbl_pkg::PIX_W-1:0] px, input logic le);
		blur_out_t                 outs[$];
		blur_out_t                 o;
		logic [bbl_pkg::PIX_W-1:0] mean;
		int                        r;
		r = (radius_reg > MAX_R) ? MAX_R : int'(radius_reg);
		o = '0;
		if (r < 2) begin
			void'(window_push(px, r, mean));
			o.pixel = px;
			outs.push_back(o);
		end else begin
			if (window_push(px, r, mean)) begin
				o.pixel = mean;
				outs.push_back(o);
			end
			// line end: repeat the last pixel to flush the owed results
			if (le) begin
				for (int k = 0; k < r / 2; k++) begin
					if (window_push(px, r, mean)) begin
						o.pixel = mean;
						outs.push_back(o);
					end
				end
			end
		end
		if (outs.size() > 0) begin
			outs[outs.size()-1].run_last = 1'b1;
			if (le)
				outs[outs.size()-1].line_done = 1'b1;
		end
		foreach (outs[i])
			blur_expect_q.push_back(outs[i]);
		if (le)
			clear_window();
	endtask

	task automatic add_pixel(input logic [bbl_pkg::PIX_W-1:0] px, input logic le,
		input bit calm);
		stim_t s;
		s.kind = ST_PIXEL;
		s.pixel = px;
		s.line_end = le;
		s.radius = '0;
		s.calm = calm;
		stim_q.push_back(s);
	endtask

	task automatic add_radius(input logic [bbl_pkg::RAD_W-1:0] r);
		stim_t s;
		s.kind = ST_RADIUS;
		s.pixel = '0;
		s.line_end = 1'b0;
		s.radius = r;
		s.calm = 1'b0;
		stim_q.push_back(s);
	endtask

	task automatic add_drain();
		stim_t s;
		s.kind = ST_DRAIN;
		s.pixel = '0;
		s.line_end = 1'b0;
		s.radius = '0;
		s.calm = 1'b0;
		stim_q.push_back(s);
	endtask

	function automatic logic [bbl_pkg::PIX_W-1:0] draw_pixel();
		logic [bbl_pkg::PIX_W-1:0] px;
		case ($urandom_range(0, 7))
			0: px = '0;
			1: px = '1;
			2: begin
				for (int ch = 0; ch < bbl_pkg::NCH; ch++)
					px[bbl_pkg::CH_W*ch +: bbl_pkg::CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			default: px = $urandom;
		endcase
		return px;
	endfunction

	// sender
	stim_t head;
	int    hold = -1;
	int    settle = 0;
	logic  present;
	logic  we_next;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_if.valid <= 1'b0;
			pix_if.pixel_in <= '0;
			pix_if.line_end <= 1'b0;
			cfg_we <= 1'b0;
			cfg_data <= '0;
			hold = -1;
			settle = 0;
		end else begin
			we_next = 1'b0;
			if (pix_if.valid && pix_if.ready) begin
				predict_blur(pix_if.pixel_in, pix_if.line_end);
				n_pixels++;
				if (pix_if.line_end)
					n_lines++;
			end
			if (!pix_if.valid || pix_if.ready) begin
				present = 1'b0;
				if (stim_q.size() > 0) begin
					head = stim_q[0];
					case (head.kind)
						ST_PIXEL: begin
							if (hold < 0)
								hold = head.calm ? 0 : $urandom_range(0, 7);
							if (hold == 0) begin
								present = 1'b1;
								pix_if.pixel_in <= head.pixel;
								pix_if.line_end <= head.line_end;
								void'(stim_q.pop_front());
								hold = -1;
							end else begin
								hold--;
							end
						end
						ST_RADIUS, ST_DRAIN: begin
							settle = (blur_expect_q.size() == 0) ? settle + 1 : 0;
							if (settle >= ((head.kind == ST_RADIUS) ? SETTLE_CYC : 1)) begin
								if (head.kind == ST_RADIUS) begin
									we_next = 1'b1;
									cfg_data <= head.radius;
									radius_reg = head.radius;
									n_radius_writes++;
								end
								void'(stim_q.pop_front());
								settle = 0;
							end
						end
						default: ;
					endcase
				end
				pix_if.valid <= present;
			end
			cfg_we <= we_next;
		end
	end

	// receiver and checker
	int        stall = 0;
	int        rx_cycles = 0;
	blur_out_t exp_res;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			stall = 0;
		end else begin
			rx_cycles++;
			if (res_if.valid && res_if.ready) begin
				if (blur_expect_q.size() == 0) begin
					$display("%0t: unexpected result pixel_out=%h run_last=%b line_done=%b",
						$time, res_if.pixel_out, res_if.run_last, res_if.line_done);
					errors++;
				end else begin
					exp_res = blur_expect_q.pop_front();
					n_checked++;
					if (res_if.pixel_out !== exp_res.pixel) begin
						$display("%0t: pixel_out expected %h actual %h",
							$time, exp_res.pixel, res_if.pixel_out);
						errors++;
					end
					if (res_if.run_last !== exp_res.run_last) begin
						$display("%0t: run_last expected %b actual %b",
							$time, exp_res.run_last, res_if.run_last);
						errors++;
					end
					if (res_if.line_done !== exp_res.line_done) begin
						$display("%0t: line_done expected %b actual %b",
							$time, exp_res.line_done, res_if.line_done);
						errors++;
					end
				end
				// after a result taken while rx_cycles modulo 1024 is below 256 the receiver does not stall
				stall = (rx_cycles % 1024 < 256) ? 0 : $urandom_range(0, 7);
			end
			if (stall > 0) begin
				stall--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	int cycle_cnt = 0;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, blur_expect_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	logic [bbl_pkg::RAD_W-1:0] phase_radius[PHASES] = '{6'd3, 6'd32, 6'd0, 6'd63, 6'd7,
		6'd1, 6'd16, 6'd33, 6'd2, 6'd31};

	initial begin
		int  len;
		int  placed;
		bit  calm;
		bit  moved;

		pix_if.valid = 1'b0;
		pix_if.pixel_in = '0;
		pix_if.line_end = 1'b0;
		res_if.ready = 1'b0;
		arst_n = 1'b0;
		radius_reg = bbl_pkg::RADIUS_RESET;
		clear_window();

		// directed: reset radius, extremes, single-pixel line
		add_pixel(32'h0000_0000, 1'b0, 1'b1);
		add_pixel(32'hFFFF_FFFF, 1'b0, 1'b1);
		add_pixel(32'h80FF_017F, 1'b1, 1'b1);
		add_pixel(32'hFFFF_FFFF, 1'b1, 1'b0);
		// pass-through at radius 0 and 1
		add_radius(6'd0);
		add_pixel(32'hA5A5_A5A5, 1'b0, 1'b0);
		add_pixel(32'h5A5A_5A5A, 1'b1, 1'b0);
		add_radius(6'd1);
		add_pixel(32'hFFFF_FFFF, 1'b0, 1'b1);
		add_pixel(32'h0123_4567, 1'b1, 1'b1);
		// short line at the largest radius, then a radius that saturates
		add_radius(6'd32);
		add_pixel(32'hFFFF_FFFF, 1'b0, 1'b0);
		add_pixel(32'h00FF_00FF, 1'b0, 1'b0);
		add_pixel(32'h1234_5678, 1'b1, 1'b0);
		add_radius(6'd63);
		add_pixel(32'hFF00_FF00, 1'b0, 1'b1);
		add_pixel(32'hFFFF_FFFF, 1'b1, 1'b1);
		// radius change in the middle of a line
		add_radius(6'd5);
		add_pixel(32'h1010_1010, 1'b0, 1'b0);
		add_pixel(32'h2020_2020, 1'b0, 1'b0);
		add_pixel(32'hF0F0_F0F0, 1'b0, 1'b0);
		add_radius(6'd8);
		add_pixel(32'h0F0F_0F0F, 1'b0, 1'b0);
		add_pixel(32'hFFFF_FFFF, 1'b1, 1'b0);
		add_drain();

		// random lines over several radius settings
		for (int ph = 0; ph < PHASES; ph++) begin
			add_radius((ph == 7 && $urandom_range(0, 1)) ? 6'($urandom_range(0, 63))
				: phase_radius[ph]);
			calm = (ph % 3 == 0);
			placed = 0;
			while (placed < PHASE_PIX) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12);
				moved = 1'b0;
				for (int i = 0; i < len; i++) begin
					add_pixel(draw_pixel(), i == len - 1, calm);
					if (!moved && i < len - 1 && $urandom_range(0, 19) == 0) begin
						add_radius(6'($urandom_range(0, 40)));
						moved = 1'b1;
					end
				end
				placed += len;
				if ($urandom_range(0, 5) == 0)
					add_drain();
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (stim_q.size() > 0 || pix_if.valid)
			@(posedge clk);
		while (blur_expect_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (blur_expect_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, blur_expect_q.size());
			errors++;
		end

		$display("Run: %0d pixels in %0d lines, %0d radius writes, %0d results compared",
			n_pixels, n_lines, n_radius_writes, n_checked);
		$display("Covered pass-through, short lines, saturated radius and mid-line changes");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
